>>> hw/rtl/tmhq_pkg.sv
// Shared types and constants for the timer min-heap queue.
// Used by tmhq_ram users, the top level and the checker; no dependencies.
package tmhq_pkg;
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = 62;
  localparam int HW    = 16;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [HW-1:0] hdl;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FIRED    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_t;
endpackage

>>> hw/rtl/tmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/timer_min_heap_queue_core.sv
// Timer queue as an array binary min-heap held in one synchronous RAM.
// Depends on tmhq_pkg and tmhq_ram.
//
//   channel | signals                                                | role
//   in      | in_valid in_ready kind time_sec time_nsec handle       | insert or expiry check
//   out     | out_valid out_ready status fired_handle last count_after | one per result
//
// One item at a time. Insert: climbs one level per parent read and compare, then posts.
// Check: reads and tests the root, and for each pop loads the last entry and sifts it
// down, reading the left then the right child; heap reads share the single read port.
// Reset clears the entry count and control; heap RAM contents need no reset.
// Results sit in an output register; a stalled output holds the sequencer.
module timer_min_heap_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [31:0]                 time_sec,
  input  logic [29:0]                 time_nsec,
  input  logic [15:0]                 handle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [15:0]                 fired_handle,
  output logic                        last,
  output logic [4:0]                  count_after
);
  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_REJ     = 11'b00000000010,
    S_INS_UP  = 11'b00000000100,
    S_INS_CMP = 11'b00000001000,
    S_INS_FIN = 11'b00000010000,
    S_CHK_RD  = 11'b00000100000,
    S_CHK_CMP = 11'b00001000000,
    S_CHK_DEC = 11'b00010000000,
    S_POP_LD  = 11'b00100000000,
    S_SD_L    = 11'b01000000000,
    S_SD_CMP  = 11'b10000000000
  } state_t;

  localparam int PW = tmhq_pkg::AW + 2;

  state_t                        state, state_next;
  logic [tmhq_pkg::CW-1:0]       count, count_next;
  logic [tmhq_pkg::AW-1:0]       pos, pos_next;
  logic [tmhq_pkg::KW-1:0]       cur_time;
  tmhq_pkg::entry_t              elem, elem_next;
  tmhq_pkg::entry_t              root, lchild;
  logic                          due, due_next;
  logic                          popped, popped_next;
  logic                          has_r;
  logic [tmhq_pkg::HW-1:0]       pend;

  logic                          we;
  logic [tmhq_pkg::AW-1:0]       waddr, raddr;
  tmhq_pkg::entry_t              wdata, rdata;
  logic [tmhq_pkg::EW-1:0]       rdata_raw;

  logic                          out_free;
  logic                          emit;
  logic [1:0]                    emit_status;
  logic [tmhq_pkg::HW-1:0]       emit_handle;
  logic                          emit_last;

  logic [PW-1:0]                 lidx, ridx;
  logic [PW-1:0]                 count_w;
  logic [tmhq_pkg::AW-1:0]       parent;
  logic [tmhq_pkg::CW-1:0]       count_dec;

  tmhq_ram #(.Width(tmhq_pkg::EW), .Depth(tmhq_pkg::DEPTH)) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rdata = rdata_raw;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign lidx      = {1'b0, pos, 1'b0} + PW'(1);
  assign ridx      = {1'b0, pos, 1'b0} + PW'(2);
  assign count_w   = PW'(count);
  assign parent    = (pos - tmhq_pkg::AW'(1)) >> 1;
  assign count_dec = count - tmhq_pkg::CW'(1);

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    elem_next   = elem;
    due_next    = due;
    popped_next = popped;
    we          = 1'b0;
    waddr       = pos;
    wdata       = elem;
    raddr       = '0;
    emit        = 1'b0;
    emit_status = tmhq_pkg::ST_NONE;
    emit_handle = '0;
    emit_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == tmhq_pkg::KIND_INSERT) begin
            if (count == tmhq_pkg::CW'(tmhq_pkg::DEPTH)) begin
              state_next = S_REJ;
            end else begin
              elem_next  = '{key: {time_sec, time_nsec}, hdl: handle};
              pos_next   = count[tmhq_pkg::AW-1:0];
              count_next = count + tmhq_pkg::CW'(1);
              state_next = S_INS_UP;
            end
          end else begin
            popped_next = 1'b0;
            state_next  = S_CHK_RD;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = tmhq_pkg::ST_FULL;
          state_next  = S_IDLE;
        end
      end
      S_INS_UP: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_INS_FIN;
        end else begin
          raddr      = parent;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (elem.key < rdata.key) begin
          wdata      = rdata;
          pos_next   = parent;
          state_next = S_INS_UP;
        end else begin
          state_next = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = tmhq_pkg::ST_INSERTED;
          state_next  = S_IDLE;
        end
      end
      S_CHK_RD: begin
        raddr = '0;
        if (count == '0) begin
          due_next   = 1'b0;
          state_next = S_CHK_DEC;
        end else begin
          state_next = S_CHK_CMP;
        end
      end
      S_CHK_CMP: begin
        due_next   = rdata.key < cur_time;
        state_next = S_CHK_DEC;
      end
      S_CHK_DEC: begin
        if (out_free || (due && !popped)) begin
          if (popped) begin
            emit        = 1'b1;
            emit_status = tmhq_pkg::ST_FIRED;
            emit_handle = pend;
            emit_last   = !due;
          end else if (!due) begin
            emit = 1'b1;
          end
          if (due) begin
            popped_next = 1'b1;
            count_next  = count_dec;
            raddr       = count_dec[tmhq_pkg::AW-1:0];
            state_next  = (count_dec == '0) ? S_CHK_RD : S_POP_LD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_POP_LD: begin
        elem_next  = rdata;
        pos_next   = '0;
        state_next = S_SD_L;
      end
      S_SD_L: begin
        if (lidx >= count_w) begin
          we         = 1'b1;
          state_next = S_CHK_RD;
        end else begin
          raddr      = lidx[tmhq_pkg::AW-1:0];
          state_next = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        // lchild was latched from the left read; rdata now holds the right child
        raddr = ridx[tmhq_pkg::AW-1:0];
        we = 1'b1;
        state_next = S_SD_L;
        if (has_r && (rdata.key < ((lchild.key < elem.key) ? lchild.key : elem.key))) begin
          wdata    = rdata;
          pos_next = ridx[tmhq_pkg::AW-1:0];
        end else if (lchild.key < elem.key) begin
          wdata    = lchild;
          pos_next = lidx[tmhq_pkg::AW-1:0];
        end else begin
          state_next = S_CHK_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // the right child read is issued in the cycle after the left one
  logic sd_r_phase;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd_r_phase <= 1'b0;
    end else begin
      sd_r_phase <= (state == S_SD_L) && (state_next == S_SD_CMP);
    end
  end

  // S_SD_CMP is held while sd_wait is set: that phase latches the left child and reads the right
  logic sd_wait;
  assign sd_wait = sd_r_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      popped    <= 1'b0;
      due       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sd_wait) begin
        state <= S_SD_CMP;
      end else begin
        state  <= state_next;
        count  <= count_next;
        popped <= popped_next;
        due    <= due_next;
      end
      if (emit && !sd_wait) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_time <= {time_sec, time_nsec};
    end
    if (sd_wait) begin
      lchild <= rdata;
      has_r  <= (ridx < count_w);
    end else begin
      pos  <= pos_next;
      elem <= elem_next;
    end
    if (state == S_CHK_RD || state == S_CHK_CMP) begin
      root <= rdata;
    end
    // hold the pending handle until the sequencer actually advances
    if (state == S_CHK_DEC && due && (out_free || !popped)) begin
      pend <= root.hdl;
    end
    if (emit && !sd_wait) begin
      status       <= emit_status;
      fired_handle <= emit_handle;
      last         <= emit_last;
      count_after  <= count;
    end
  end
endmodule

>>> hw/rtl/tmhq_chk.sv
// Port-level checker for timer_min_heap_queue_core, bound to the top level.
// Depends on tmhq_pkg.
module tmhq_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] fired_handle,
  input logic        last,
  input logic [4:0]  count_after
);
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_after <= 5'(tmhq_pkg::DEPTH))
    else $error("count_after out of range");

  a_only_fired_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> status == tmhq_pkg::ST_FIRED)
    else $error("non-final result that is not a fired timer");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != tmhq_pkg::ST_FIRED) |-> fired_handle == '0)
    else $error("handle set on a non-fired result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status) && $stable(last))
    else $error("result dropped under stall");

  a_busy_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> !in_ready)
    else $error("input taken before final result");
endmodule

bind timer_min_heap_queue_core tmhq_chk u_tmhq_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .fired_handle (fired_handle),
  .last         (last),
  .count_after  (count_after)
);

>>> dv/tb_top.sv
// Self-checking testbench for the timer min-heap queue core.
// Drives inserts and expiry checks, predicts results with a behavioral heap.
// Depends on tmhq_pkg and timer_min_heap_queue_core.
`timescale 1ns / 1ps

module tb_top;
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fired_handle;
    logic        last;
    logic [4:0]  count_after;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [31:0] time_sec = '0;
  logic [29:0] time_nsec = '0;
  logic [15:0] handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] fired_handle;
  logic        last;
  logic [4:0]  count_after;

  // Predictor state
  logic [61:0] pq_key[tmhq_pkg::DEPTH];
  logic [15:0] pq_hdl[tmhq_pkg::DEPTH];
  int          pq_count;
  result_t     expected_results[$];

  int errors = 0;
  int cycle_count = 0;

  timer_min_heap_queue_core i_dut (
    .clk, .rst, .in_valid, .in_ready, .kind, .time_sec, .time_nsec, .handle,
    .out_valid, .out_ready, .status, .fired_handle, .last, .count_after
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timer_min_heap_queue_core: mismatch");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    errors++;
  endtask

  function automatic void slot_swap(int a, int b);
    logic [61:0] k;
    logic [15:0] h;
    k = pq_key[a]; h = pq_hdl[a];
    pq_key[a] = pq_key[b]; pq_hdl[a] = pq_hdl[b];
    pq_key[b] = k; pq_hdl[b] = h;
  endfunction

  function automatic void push_result(tmhq_pkg::status_t st, logic [15:0] h, logic lst);
    result_t r;
    r.status = st; r.fired_handle = h; r.last = lst; r.count_after = pq_count[4:0];
    expected_results.push_back(r);
  endfunction

  function automatic void predict_timer_queue(tmhq_pkg::kind_t k, logic [31:0] s,
                                              logic [29:0] ns, logic [15:0] h);
    logic [61:0] key;
    int pos, up, l, r, best, fired;
    logic [15:0] top;
    key = {s, ns};
    if (k == tmhq_pkg::KIND_INSERT) begin
      if (pq_count >= tmhq_pkg::DEPTH) begin
        push_result(tmhq_pkg::ST_FULL, 16'd0, 1'b1);
        return;
      end
      pq_key[pq_count] = key;
      pq_hdl[pq_count] = h;
      pos = pq_count;
      pq_count++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (pq_key[pos] < pq_key[up]) begin
          slot_swap(pos, up);
          pos = up;
        end else break;
      end
      push_result(tmhq_pkg::ST_INSERTED, 16'd0, 1'b1);
      return;
    end
    fired = 0;
    while (pq_count > 0 && pq_key[0] < key) begin
      top = pq_hdl[0];
      pq_count--;
      pq_key[0] = pq_key[pq_count];
      pq_hdl[0] = pq_hdl[pq_count];
      pos = 0;
      while (pos < pq_count) begin
        l = 2 * pos + 1; r = 2 * pos + 2; best = pos;
        if (l < pq_count && pq_key[l] < pq_key[best]) best = l;
        if (r < pq_count && pq_key[r] < pq_key[best]) best = r;
        if (best == pos) break;
        slot_swap(pos, best);
        pos = best;
      end
      push_result(tmhq_pkg::ST_FIRED, top, 1'b0);
      fired++;
    end
    if (fired == 0) push_result(tmhq_pkg::ST_NONE, 16'd0, 1'b1);
    else expected_results[$].last = 1'b1;
  endfunction

  // Entered and left at a falling edge; valid stays up across a zero gap
  task automatic send_item(tmhq_pkg::kind_t k, logic [31:0] s, logic [29:0] ns,
                           logic [15:0] h);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= k; time_sec <= s; time_nsec <= ns; handle <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_timer_queue(k, s, ns, h);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Output stall: random per result, with quiet stretches of always-ready
  initial begin
    int stall;
    @(negedge clk);
    while (1) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result status", 32'(status), 32'd0);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (status !== e.status) report("status", 32'(status), 32'(e.status));
        if (fired_handle !== e.fired_handle)
          report("fired_handle", 32'(fired_handle), 32'(e.fired_handle));
        if (last !== e.last) report("last", 32'(last), 32'(e.last));
        if (count_after !== e.count_after)
          report("count_after", 32'(count_after), 32'(e.count_after));
      end
    end
  end

  task automatic test_directed();
    send_item(tmhq_pkg::KIND_CHECK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 16'hFFFF);  // empty heap
    send_item(tmhq_pkg::KIND_INSERT, 32'd5, 30'd100, 16'hFFFF);
    send_item(tmhq_pkg::KIND_INSERT, 32'd5, 30'd100, 16'h0001);  // equal key
    send_item(tmhq_pkg::KIND_INSERT, 32'd0, 30'd0, 16'h0000);
    send_item(tmhq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 16'hAAAA);
    send_item(tmhq_pkg::KIND_INSERT, 32'd4, 30'd999999999, 16'h5555);
    send_item(tmhq_pkg::KIND_CHECK, 32'd0, 30'd0, 16'd0);      // equal to earliest: not due
    send_item(tmhq_pkg::KIND_CHECK, 32'd5, 30'd100, 16'd0);    // pops two below
    send_item(tmhq_pkg::KIND_CHECK, 32'd5, 30'd101, 16'd0);    // equal pair
    send_item(tmhq_pkg::KIND_INSERT, 32'd6, 30'h3FFF_FFFF, 16'h1234);  // nsec over 1e9
    send_item(tmhq_pkg::KIND_CHECK, 32'd7, 30'd0, 16'd0);
    for (int i = 0; i < 17; i++)  // fill, then reject
      send_item(tmhq_pkg::KIND_INSERT, $urandom_range(0, 3), 30'($urandom_range(0, 3)),
                i[15:0]);
    send_item(tmhq_pkg::KIND_CHECK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 16'd0);  // drains all but the max-key entry
  endtask

  task automatic test_random(int n_items);
    logic [31:0] s;
    logic [29:0] ns;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        s = $urandom(); ns = 30'($urandom());
      end else begin
        s = $urandom_range(0, 7); ns = 30'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 99) < 65)
        send_item(tmhq_pkg::KIND_INSERT, s, ns, 16'($urandom()));
      else
        send_item(tmhq_pkg::KIND_CHECK, s, ns, 16'($urandom()));
      if (i == n_items / 2) wait_drained();  // pause sender until all results are in
    end
  endtask

  initial begin
    pq_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(220);
    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("timer_min_heap_queue_core: match");
    else
      $display("timer_min_heap_queue_core: mismatch");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/tmhq_pkg.sv
hw/rtl/tmhq_ram.sv
hw/rtl/timer_min_heap_queue_core.sv
hw/rtl/tmhq_chk.sv
dv/tb_top.sv
